[src/hysteretic_deadband_qualifier_macros.svh]
// Assertion macros shared by the hysteretic deadband qualifier RTL.
`ifndef HYSTERETIC_DEADBAND_QUALIFIER_MACROS_SVH
`define HYSTERETIC_DEADBAND_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define HDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define HDQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define HDQ_ASSERT(lbl, prop, msg)
`define HDQ_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[src/hdq_pkg.sv]
// Types, codes and constants of the hysteretic deadband qualifier.
`timescale 1ns / 1ps
package hdq_pkg;

	// Fixed field widths
	localparam int COUNT_W     = 64;
	localparam int THR_W       = 16;
	localparam int PERSIST_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int REG_IDX_W   = 2;
	localparam int MODE_W      = 2;
	localparam int REASON_W    = 4;
	localparam int CAUSE_W     = 2;

	// Default parameter values
	localparam int DEF_ID_BITS      = 32;
	localparam int DEF_PENDING_BITS = 8;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_THR   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE_THR = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PERSIST     = 2'd2;

	// Register reset values
	localparam logic [THR_W-1:0]     RST_ENTRY_THR   = 16'd2;
	localparam logic [THR_W-1:0]     RST_RELEASE_THR = 16'd4;
	localparam logic [PERSIST_W-1:0] RST_PERSIST     = 8'd3;

	// Magnitude that gets its own hold reason
	localparam logic [COUNT_W-1:0] MAG_THREE = 64'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_REQUAL  = 2'd0,
		MODE_OUTSIDE = 2'd1,
		MODE_INSIDE  = 2'd2
	} mode_t;

	typedef enum logic [REASON_W-1:0] {
		RSN_SESSION_CHANGE = 4'd0,
		RSN_EPOCH_CHANGE   = 4'd1,
		RSN_INVALID        = 4'd2,
		RSN_ENTRY_PENDING  = 4'd3,
		RSN_ENTRY_CONFIRM  = 4'd4,
		RSN_THREE_OUTSIDE  = 4'd5,
		RSN_OUTSIDE_LOOSE  = 4'd6,
		RSN_RELEASE_PEND   = 4'd7,
		RSN_RELEASE_CONFIRM = 4'd8,
		RSN_THREE_INSIDE   = 4'd9,
		RSN_INSIDE_HOLD    = 4'd10
	} reason_t;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_SESSION = 2'd0,
		CAUSE_EPOCH   = 2'd1,
		CAUSE_INVALID = 2'd2
	} cause_t;

	// Qualifier state flags
	typedef struct packed {
		mode_t mode;
		logic  sess_known;
		logic  epoch_seen;
	} hdq_flags_t;

	// Per-word decision from the step logic
	typedef struct packed {
		mode_t   mode_before;
		mode_t   mode_after;
		reason_t reason;
		logic    mag_valid;
		logic    id_requal;
		cause_t  cause;
		logic    eligible;
	} hdq_verdict_t;

endpackage

[src/hdq_if.sv]
// Valid/ready channel interfaces for estimates in and qualification results out.
`timescale 1ns / 1ps
interface hdq_in_if #(
	parameter int ID_BITS = hdq_pkg::DEF_ID_BITS
);
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic [ID_BITS-1:0]                  session_id;
	logic [ID_BITS-1:0]                  epoch_id;
	logic                                is_fresh;
	logic                                count_valid;
	logic signed [hdq_pkg::COUNT_W-1:0]  error_count;

	modport source (
		output valid, cmd, session_id, epoch_id, is_fresh, count_valid, error_count,
		input  ready
	);
	modport sink (
		input  valid, cmd, session_id, epoch_id, is_fresh, count_valid, error_count,
		output ready
	);
endinterface

interface hdq_out_if #(
	parameter int PENDING_BITS = hdq_pkg::DEF_PENDING_BITS
);
	logic                             valid;
	logic                             ready;
	logic [hdq_pkg::MODE_W-1:0]       mode_before;
	logic [hdq_pkg::MODE_W-1:0]       mode_after;
	logic [hdq_pkg::REASON_W-1:0]     reason_code;
	logic                             magnitude_valid;
	logic [hdq_pkg::COUNT_W-1:0]      magnitude;
	logic [PENDING_BITS-1:0]          entry_pending;
	logic [PENDING_BITS-1:0]          release_pending;
	logic                             controller_eligible;
	logic                             id_requalified;
	logic [hdq_pkg::CAUSE_W-1:0]      requalify_cause;

	modport source (
		output valid, mode_before, mode_after, reason_code, magnitude_valid, magnitude,
			entry_pending, release_pending, controller_eligible, id_requalified,
			requalify_cause,
		input  ready
	);
	modport sink (
		input  valid, mode_before, mode_after, reason_code, magnitude_valid, magnitude,
			entry_pending, release_pending, controller_eligible, id_requalified,
			requalify_cause,
		output ready
	);
endinterface

[src/hdq_step.sv]
// Next-state and result logic for one estimate word of the qualifier.
`timescale 1ns / 1ps
module hdq_step #(
	parameter int ID_BITS      = hdq_pkg::DEF_ID_BITS,
	parameter int PENDING_BITS = hdq_pkg::DEF_PENDING_BITS
) (
	// current state
	input  hdq_pkg::hdq_flags_t                flags,
	input  logic [ID_BITS-1:0]                 last_session,
	input  logic [ID_BITS-1:0]                 last_epoch,
	input  logic [PENDING_BITS-1:0]            entry_cnt,
	input  logic [PENDING_BITS-1:0]            release_cnt,
	// configuration
	input  logic [hdq_pkg::THR_W-1:0]          entry_thr,
	input  logic [hdq_pkg::THR_W-1:0]          release_thr,
	input  logic [hdq_pkg::PERSIST_W-1:0]      persist,
	// estimate word
	input  logic                               cmd,
	input  logic [ID_BITS-1:0]                 session_id,
	input  logic [ID_BITS-1:0]                 epoch_id,
	input  logic                               is_fresh,
	input  logic                               count_valid,
	input  logic [hdq_pkg::COUNT_W-1:0]        error_count,
	// next state
	output hdq_pkg::hdq_flags_t                flags_nxt,
	output logic [ID_BITS-1:0]                 last_session_nxt,
	output logic [ID_BITS-1:0]                 last_epoch_nxt,
	output logic [PENDING_BITS-1:0]            entry_cnt_nxt,
	output logic [PENDING_BITS-1:0]            release_cnt_nxt,
	// result
	output hdq_pkg::hdq_verdict_t              verdict,
	output logic [hdq_pkg::COUNT_W-1:0]        magnitude
);
	import hdq_pkg::*;

	localparam int CMP_W = (PENDING_BITS > PERSIST_W) ? PENDING_BITS : PERSIST_W;

	logic                    sess_chg;
	logic                    ep_chg;
	logic                    item_ok;
	logic [COUNT_W-1:0]      mag;
	logic                    mag_hi_zero;
	logic                    entry_qual;
	logic                    release_qual;
	logic                    mag_is_three;
	mode_t                   mode_id;
	mode_t                   mode_work;
	logic [PENDING_BITS-1:0] ec_id;
	logic [PENDING_BITS-1:0] rc_id;
	logic [PENDING_BITS-1:0] ec_inc;
	logic [PENDING_BITS-1:0] rc_inc;
	logic                    ec_done;
	logic                    rc_done;

	assign item_ok  = is_fresh & count_valid;
	assign sess_chg = flags.sess_known && (session_id != last_session);
	assign ep_chg   = !sess_chg && flags.epoch_seen && (epoch_id != last_epoch);

	// Absolute value, most negative count wraps to itself
	assign mag          = error_count[COUNT_W-1] ? (COUNT_W'(0) - error_count) : error_count;
	assign mag_hi_zero  = ~|mag[COUNT_W-1:THR_W];
	assign entry_qual   = mag_hi_zero && (mag[THR_W-1:0] <= entry_thr);
	assign release_qual = !mag_hi_zero || (mag[THR_W-1:0] >= release_thr);
	assign mag_is_three = (mag == MAG_THREE);

	// Identity change drops back to requalify before the estimate is judged
	assign mode_id   = (sess_chg || ep_chg) ? MODE_REQUAL : flags.mode;
	assign ec_id     = (sess_chg || ep_chg) ? '0 : entry_cnt;
	assign rc_id     = (sess_chg || ep_chg) ? '0 : release_cnt;
	assign mode_work = (mode_id == MODE_REQUAL) ? MODE_OUTSIDE : mode_id;

	// Saturating persistence counters
	assign ec_inc  = (&ec_id) ? ec_id : ec_id + 1'b1;
	assign rc_inc  = (&rc_id) ? rc_id : rc_id + 1'b1;
	assign ec_done = CMP_W'(ec_inc) >= CMP_W'(persist);
	assign rc_done = CMP_W'(rc_inc) >= CMP_W'(persist);

	always_comb begin
		flags_nxt        = flags;
		last_session_nxt = last_session;
		last_epoch_nxt   = last_epoch;
		entry_cnt_nxt    = '0;
		release_cnt_nxt  = '0;
		verdict.mode_before = flags.mode;
		verdict.mag_valid   = item_ok;
		verdict.id_requal   = sess_chg || ep_chg;
		verdict.cause       = sess_chg ? CAUSE_SESSION : (ep_chg ? CAUSE_EPOCH : CAUSE_INVALID);
		verdict.reason      = RSN_INVALID;
		magnitude           = '0;

		if (cmd) begin
			// forced requalify, identities kept
			flags_nxt.mode = MODE_REQUAL;
		end else begin
			last_session_nxt     = session_id;
			last_epoch_nxt       = epoch_id;
			flags_nxt.sess_known = 1'b1;
			flags_nxt.epoch_seen = 1'b1;
			if (!item_ok) begin
				flags_nxt.mode = MODE_REQUAL;
			end else begin
				magnitude = mag;
				if (mode_work == MODE_OUTSIDE) begin
					if (entry_qual) begin
						if (ec_done) begin
							flags_nxt.mode = MODE_INSIDE;
							verdict.reason = RSN_ENTRY_CONFIRM;
						end else begin
							flags_nxt.mode = MODE_OUTSIDE;
							entry_cnt_nxt  = ec_inc;
							verdict.reason = RSN_ENTRY_PENDING;
						end
					end else begin
						flags_nxt.mode = MODE_OUTSIDE;
						verdict.reason = mag_is_three ? RSN_THREE_OUTSIDE : RSN_OUTSIDE_LOOSE;
					end
				end else begin
					if (release_qual) begin
						if (rc_done) begin
							flags_nxt.mode = MODE_OUTSIDE;
							verdict.reason = RSN_RELEASE_CONFIRM;
						end else begin
							flags_nxt.mode  = MODE_INSIDE;
							release_cnt_nxt = rc_inc;
							verdict.reason  = RSN_RELEASE_PEND;
						end
					end else begin
						flags_nxt.mode = MODE_INSIDE;
						verdict.reason = mag_is_three ? RSN_THREE_INSIDE : RSN_INSIDE_HOLD;
					end
				end
			end
		end

		verdict.mode_after = flags_nxt.mode;
		verdict.eligible   = (flags_nxt.mode == MODE_OUTSIDE) && (entry_cnt_nxt == '0)
			&& (release_cnt_nxt == '0);
	end

endmodule

[src/hysteretic_deadband_qualifier.sv]
// Top level of the hysteretic deadband qualifier: word registers, state and config.
//
//  channel   dir  handshake        word
//  --------  ---  ---------------  ------------------------------------------------
//  sample    in   valid / ready    cmd, ids, freshness, count valid, error count
//  result    out  valid / ready    modes, reason, magnitude, pending counts, flags
//  wr_*      in   wr_en only       register index and data, no back-pressure
//
// One word per cycle sustained while the result sink keeps up. A word sits in the
// input register, where the step logic judges it against the qualifier state; an
// observe word then moves on to the result register, which offers it on the
// result channel until the sink takes it.
// A force command updates the state and produces no result word.
// Reset clears mode, counters, seen flags and loads the register defaults.
// A stalled result holds in its register; the input register keeps accepting
// as long as the word it holds can retire.
`timescale 1ns / 1ps
module hysteretic_deadband_qualifier #(
	parameter int ID_BITS      = hdq_pkg::DEF_ID_BITS,
	parameter int PENDING_BITS = hdq_pkg::DEF_PENDING_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	hdq_in_if.sink                            sample,
	hdq_out_if.source                         result,
	input  logic                              wr_en,
	input  logic [hdq_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [hdq_pkg::CFG_DATA_W-1:0]    wr_data
);
	import hdq_pkg::*;

	`include "hysteretic_deadband_qualifier_macros.svh"

	// configuration registers
	logic [THR_W-1:0]        entry_thr_q;
	logic [THR_W-1:0]        release_thr_q;
	logic [PERSIST_W-1:0]    persist_q;

	// qualifier state
	hdq_flags_t              flags_q;
	logic [ID_BITS-1:0]      last_session_q;
	logic [ID_BITS-1:0]      last_epoch_q;
	logic [PENDING_BITS-1:0] entry_cnt_q;
	logic [PENDING_BITS-1:0] release_cnt_q;

	// input register
	logic                    valid_s1;
	logic                    cmd_s1;
	logic [ID_BITS-1:0]      session_s1;
	logic [ID_BITS-1:0]      epoch_s1;
	logic                    fresh_s1;
	logic                    count_valid_s1;
	logic [COUNT_W-1:0]      error_count_s1;

	// result register
	logic                    valid_s2;
	hdq_verdict_t            verdict_s2;
	logic [COUNT_W-1:0]      magnitude_s2;
	logic [PENDING_BITS-1:0] entry_pend_s2;
	logic [PENDING_BITS-1:0] release_pend_s2;

	// step logic outputs
	hdq_flags_t              flags_nxt;
	logic [ID_BITS-1:0]      last_session_nxt;
	logic [ID_BITS-1:0]      last_epoch_nxt;
	logic [PENDING_BITS-1:0] entry_cnt_nxt;
	logic [PENDING_BITS-1:0] release_cnt_nxt;
	hdq_verdict_t            verdict;
	logic [COUNT_W-1:0]      magnitude;

	logic                    retire_s1;
	logic                    load_s2;
	logic                    take_in;

	// A command retires at once; an observe word needs room in the result register
	assign retire_s1    = valid_s1 && (cmd_s1 || !valid_s2 || result.ready);
	assign load_s2      = retire_s1 && !cmd_s1;
	assign sample.ready = !valid_s1 || retire_s1;
	assign take_in      = sample.valid && sample.ready;

	hdq_step #(
		.ID_BITS      (ID_BITS),
		.PENDING_BITS (PENDING_BITS)
	) u_step (
		.flags            (flags_q),
		.last_session     (last_session_q),
		.last_epoch       (last_epoch_q),
		.entry_cnt        (entry_cnt_q),
		.release_cnt      (release_cnt_q),
		.entry_thr        (entry_thr_q),
		.release_thr      (release_thr_q),
		.persist          (persist_q),
		.cmd              (cmd_s1),
		.session_id       (session_s1),
		.epoch_id         (epoch_s1),
		.is_fresh         (fresh_s1),
		.count_valid      (count_valid_s1),
		.error_count      (error_count_s1),
		.flags_nxt        (flags_nxt),
		.last_session_nxt (last_session_nxt),
		.last_epoch_nxt   (last_epoch_nxt),
		.entry_cnt_nxt    (entry_cnt_nxt),
		.release_cnt_nxt  (release_cnt_nxt),
		.verdict          (verdict),
		.magnitude        (magnitude)
	);

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_thr_q   <= RST_ENTRY_THR;
			release_thr_q <= RST_RELEASE_THR;
			persist_q     <= RST_PERSIST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ENTRY_THR:   entry_thr_q   <= wr_data[THR_W-1:0];
				REG_RELEASE_THR: release_thr_q <= wr_data[THR_W-1:0];
				REG_PERSIST:     persist_q     <= wr_data[PERSIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the qualifier state as each word retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q        <= '{mode: MODE_REQUAL, sess_known: 1'b0, epoch_seen: 1'b0};
			last_session_q <= '0;
			last_epoch_q   <= '0;
			entry_cnt_q    <= '0;
			release_cnt_q  <= '0;
		end else if (retire_s1) begin
			flags_q        <= flags_nxt;
			last_session_q <= last_session_nxt;
			last_epoch_q   <= last_epoch_nxt;
			entry_cnt_q    <= entry_cnt_nxt;
			release_cnt_q  <= release_cnt_nxt;
		end
	end

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1         <= sample.cmd;
			session_s1     <= sample.session_id;
			epoch_s1       <= sample.epoch_id;
			fresh_s1       <= sample.is_fresh;
			count_valid_s1 <= sample.count_valid;
			error_count_s1 <= sample.error_count;
		end
	end

	// Result register: valid bit, hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			verdict_s2      <= verdict;
			magnitude_s2    <= magnitude;
			entry_pend_s2   <= entry_cnt_nxt;
			release_pend_s2 <= release_cnt_nxt;
		end
	end

	assign result.valid               = valid_s2;
	assign result.mode_before         = verdict_s2.mode_before;
	assign result.mode_after          = verdict_s2.mode_after;
	assign result.reason_code         = verdict_s2.reason;
	assign result.magnitude_valid     = verdict_s2.mag_valid;
	assign result.magnitude           = magnitude_s2;
	assign result.entry_pending       = entry_pend_s2;
	assign result.release_pending     = release_pend_s2;
	assign result.controller_eligible = verdict_s2.eligible;
	assign result.id_requalified      = verdict_s2.id_requal;
	assign result.requalify_cause     = verdict_s2.cause;

	// Only one persistence counter runs at a time
	`HDQ_ASSERT_NEVER(a_one_counter, (entry_cnt_q != '0) && (release_cnt_q != '0), "both pending counters nonzero")
	// Requalify mode carries no pending count
	`HDQ_ASSERT(a_requal_clear, (flags_q.mode == MODE_REQUAL) |-> ((entry_cnt_q == '0) && (release_cnt_q == '0)), "pending count in requalify mode")
	// A retired command leaves the block in requalify
	`HDQ_ASSERT(a_cmd_requal, (retire_s1 && cmd_s1) |=> (flags_q.mode == MODE_REQUAL), "command did not requalify")
	// A retired observe word shows up as a result that matches the new state
	`HDQ_ASSERT(a_result_loaded, load_s2 |=> (valid_s2 && (result.mode_after == flags_q.mode) && (result.entry_pending == entry_cnt_q)), "result does not match state")
	// A command never produces a result word
	`HDQ_ASSERT(a_cmd_silent, (retire_s1 && cmd_s1 && !valid_s2) |=> !valid_s2, "command produced a result")

endmodule
